@@ src/oaht_pkg.sv @@
`timescale 1ns / 1ps

package oaht_pkg;

  // Table geometry
  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = 9;
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int HASH_W = 32;

  localparam logic [CNT_W-1:0] FILL_LIMIT_RESET = CNT_W'(192);

  // Request opcodes
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Response status codes
  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_MISSING = 2'd1,
    RES_FULL    = 2'd2
  } res_t;

  // Slot status codes; code 3 is never written and reads as empty
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  // Controller to slot memory
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             st_we;
    slot_st_t         st_data;
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_value;
  } mem_req_t;

  // Slot memory read data, registered
  typedef struct packed {
    slot_st_t         status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } mem_rsp_t;

endpackage

@@ src/oaht_slot_mem.sv @@
`timescale 1ns / 1ps

module oaht_slot_mem (
  input  logic              clk,
  input  logic              rst,
  input  oaht_pkg::mem_req_t req,
  output oaht_pkg::mem_rsp_t rsp
);
  import oaht_pkg::*;

  logic [1:0]       status_mem [SLOTS];
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0] valid;

  logic [1:0]       status_rd;
  logic             valid_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  // Per-slot valid bits: an unwritten slot reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.st_we) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // Status memory
  always_ff @(posedge clk) begin
    if (req.st_we) begin
      status_mem[req.wr_addr] <= req.st_data;
    end
    if (req.rd_en) begin
      status_rd <= status_mem[req.rd_addr];
      valid_rd  <= valid[req.rd_addr];
    end
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.wr_addr] <= req.wr_key;
    end
    if (req.rd_en) begin
      key_rd <= key_mem[req.rd_addr];
    end
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (req.val_we) begin
      val_mem[req.wr_addr] <= req.wr_value;
    end
    if (req.rd_en) begin
      val_rd <= val_mem[req.rd_addr];
    end
  end

  // Read data out; code 3 folds into empty
  always_comb begin
    rsp.key   = key_rd;
    rsp.value = val_rd;
    if (!valid_rd) begin
      rsp.status = ST_EMPTY;
    end else if (status_rd == ST_LIVE) begin
      rsp.status = ST_LIVE;
    end else if (status_rd == ST_TOMB) begin
      rsp.status = ST_TOMB;
    end else begin
      rsp.status = ST_EMPTY;
    end
  end

endmodule

@@ src/oaht_ctrl.sv @@
`timescale 1ns / 1ps

module oaht_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [oaht_pkg::CNT_W-1:0]   fill_limit,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   opcode,
  input  logic [oaht_pkg::KEY_W-1:0]   key,
  input  logic [oaht_pkg::HASH_W-1:0]  key_hash,
  input  logic [oaht_pkg::VAL_W-1:0]   value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic                         new_key,
  output logic [oaht_pkg::VAL_W-1:0]   found_value,
  output logic [oaht_pkg::CNT_W-1:0]   filled_slots,
  output logic                         table_empty,
  output oaht_pkg::mem_req_t           mem_req,
  input  oaht_pkg::mem_rsp_t           mem_rsp
);
  import oaht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_REPLY
  } state_t;

  state_t           state;
  logic [1:0]       op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] tomb;
  logic             have_tomb;
  logic [CNT_W-1:0] fill_count;
  res_t             res_status;
  logic             res_fresh;
  logic [VAL_W-1:0] res_found;

  logic             is_live;
  logic             is_tomb;
  logic             is_empty;
  logic             key_hit;
  logic             last;
  logic             place;
  logic             bump;
  logic             finish;
  logic [CNT_W:0]   count_inc;
  logic             over_limit;
  logic             out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Add is refused once the fill limit is reached
  assign count_inc  = {1'b0, fill_count} + (CNT_W + 1)'(1);
  assign over_limit = count_inc > {1'b0, fill_limit};

  // Probe decision on the slot just read
  always_comb begin
    is_live  = (mem_rsp.status == ST_LIVE);
    is_tomb  = (mem_rsp.status == ST_TOMB);
    is_empty = !is_live && !is_tomb;
    key_hit  = is_live && (mem_rsp.key == key_q);
    last     = (n == {IDX_W{1'b1}});
    place    = !key_hit && (op_q == OP_ADD) &&
               (is_empty || (last && (have_tomb || is_tomb)));
    bump     = place && is_empty && !have_tomb;
    finish   = key_hit || is_empty || last;
  end

  // Memory requests: read in S_READ, update in S_CHECK
  always_comb begin
    mem_req          = '0;
    mem_req.st_data  = ST_EMPTY;
    mem_req.rd_en    = (state == S_READ);
    mem_req.rd_addr  = idx;
    mem_req.wr_addr  = idx;
    mem_req.wr_key   = key_q;
    mem_req.wr_value = value_q;
    if (state == S_CHECK) begin
      if (key_hit) begin
        if (op_q == OP_ADD) begin
          mem_req.val_we = 1'b1;
        end else if (op_q == OP_REMOVE) begin
          mem_req.st_we   = 1'b1;
          mem_req.st_data = ST_TOMB;
        end
      end else if (place) begin
        mem_req.wr_addr = have_tomb ? tomb : idx;
        mem_req.st_we   = 1'b1;
        mem_req.st_data = ST_LIVE;
        mem_req.key_we  = 1'b1;
        mem_req.val_we  = 1'b1;
      end
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // S_REPLY reloads the output register itself
      if (rsp_valid && !rsp_stall && state != S_REPLY) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q      <= opcode;
            key_q     <= key;
            value_q   <= value;
            idx       <= key_hash[IDX_W-1:0];
            n         <= '0;
            have_tomb <= 1'b0;
            res_fresh <= 1'b0;
            res_found <= '0;
            if (opcode == OP_ADD && over_limit) begin
              res_status <= RES_FULL;
              state      <= S_REPLY;
            end else if (opcode != OP_GET && opcode != OP_ADD &&
                         opcode != OP_REMOVE) begin
              res_status <= RES_MISSING;
              state      <= S_REPLY;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (finish) begin
            if (key_hit) begin
              res_status <= RES_OK;
              if (op_q == OP_GET) begin
                res_found <= mem_rsp.value;
              end
            end else if (place) begin
              res_status <= RES_OK;
              res_fresh  <= 1'b1;
            end else if (op_q == OP_ADD) begin
              res_status <= RES_FULL;
            end else begin
              res_status <= RES_MISSING;
            end
            if (bump && fill_count != {CNT_W{1'b1}}) begin
              fill_count <= fill_count + CNT_W'(1);
            end
            state <= S_REPLY;
          end else begin
            if (is_tomb && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb      <= idx;
            end
            idx   <= idx + IDX_W'(1);
            n     <= n + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            status       <= res_status;
            new_key      <= res_fresh;
            found_value  <= res_found;
            filled_slots <= fill_count;
            table_empty  <= (fill_count == '0);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/open_address_hash_table_unit.sv @@
`timescale 1ns / 1ps

// Open-addressing hash table, 256 slots, linear probing with tombstones.
// Request channel (req_valid / req_stall): opcode, key, key_hash, value. A
// transfer happens when req_valid is high and req_stall is low; req_stall
// stays high from the transfer until the result is loaded into the output
// register, so one request is worked at a time.
// Response channel (rsp_valid / rsp_stall): status, new_key, found_value,
// filled_slots, table_empty, held in an output register until transferred.
// Sequence: each probed slot takes a registered memory read, then key
// compare and update; a request is accepted, its slots are probed in turn,
// up to all 256 for a full pass, and its result is loaded. Requests
// rejected up front go straight from acceptance to loading the result.
// A stalled response holds; the next request is still accepted and worked,
// and waits to load its result until the output register frees up.
// Reset clears slot status (per-slot valid bits), the fill count and the
// fill limit (to 192); the block comes out of reset idle and takes requests.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes the fill limit;
// cfg_ready is always high. Write it only while the block is idle.
module open_address_hash_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [oaht_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   opcode,
  input  logic [oaht_pkg::KEY_W-1:0]   key,
  input  logic [oaht_pkg::HASH_W-1:0]  key_hash,
  input  logic [oaht_pkg::VAL_W-1:0]   value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic                         new_key,
  output logic [oaht_pkg::VAL_W-1:0]   found_value,
  output logic [oaht_pkg::CNT_W-1:0]   filled_slots,
  output logic                         table_empty
);
  import oaht_pkg::*;

  logic [CNT_W-1:0] fill_limit;
  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;

  // Fill limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= FILL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fill_limit <= cfg_data;
    end
  end

  oaht_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fill_limit   (fill_limit),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .key          (key),
    .key_hash     (key_hash),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .new_key      (new_key),
    .found_value  (found_value),
    .filled_slots (filled_slots),
    .table_empty  (table_empty),
    .mem_req      (mem_req),
    .mem_rsp      (mem_rsp)
  );

  oaht_slot_mem u_slot_mem (
    .clk (clk),
    .rst (rst),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule
